### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands; expect aclk and aresetn in the including scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WRSI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WRSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wrsi_pkg.sv
// ----------------------------------------------------------------------------
// wrsi_pkg
// Widths, constants, state encoding and control bundles of the RSI unit.
// ----------------------------------------------------------------------------
package wrsi_pkg;

    // field and state widths
    localparam int PRICE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int GL_W      = PRICE_W + FRAC_W;
    localparam int ACC_W     = 56;
    localparam int PERIOD_W  = 8;
    localparam int CNT_W     = 9;
    localparam int RSI_W     = 23;

    // divider and ratio datapath widths
    localparam int DIVD_W    = ACC_W + PERIOD_W;
    localparam int SUM_W     = ACC_W + 1;
    localparam int RAT_W     = ACC_W + 3;
    localparam int STEP_W    = $clog2(DIVD_W);
    localparam int RSI_IDX_W = $clog2(RSI_W);

    // loop lengths
    localparam int DIV_STEPS   = DIVD_W;
    localparam int RATIO_STEPS = RSI_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
    localparam logic [CNT_W-1:0]    COUNT_MAX    = '1;
    localparam logic [ACC_W-1:0]    ACC_MAX      = '1;
    localparam logic [RSI_W-1:0]    RSI_FULL     = RSI_W'(6553600);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_SEED,
        ST_SMOOTH,
        ST_DIV,
        ST_DIV_END,
        ST_RATIO_INIT,
        ST_RATIO,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic                 load;
        logic                 acc;
        logic                 seed;
        logic                 smooth;
        logic                 div_step;
        logic                 div_done;
        logic                 ratio_init;
        logic                 ratio_step;
        logic [RSI_IDX_W-1:0] ratio_idx;
        logic                 out_load;
        logic                 res_ready;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt_p;
        logic cnt_eq_p;
        logic loss_zero;
    } status_t;

endpackage

### design/wilder_rsi_stream_unit.sv
// ----------------------------------------------------------------------------
// wilder_rsi_stream_unit
// Streaming RSI with Wilder smoothing over a configurable period.
//
//   channel  | ports                               | beat
//   ---------+-------------------------------------+---------------------------
//   input    | s_valid s_ready s_price             | one price in ticks
//   result   | m_valid m_ready m_ready_res m_rsi   | ready flag, RSI in Q7.16
//   config   | cfg_valid cfg_ready cfg_data        | period, write only
//
// Per price: load; past the first price, accumulate while warming up, or
// seed or smooth, divide by period (radix-2, both averages at once) and run
// the Q7.16 ratio loop, skipped when the average loss is zero; then output.
// Synchronous reset clears control, count and averages; period goes to 14.
// A held result stalls only the final output load; the next price is taken
// as soon as the result sits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wilder_rsi_stream_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // price input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wrsi_pkg::PRICE_W-1:0]  s_price,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ready_res,
    output logic [wrsi_pkg::RSI_W-1:0]    m_rsi,
    // period register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wrsi_pkg::PERIOD_W-1:0] cfg_data
);

    wrsi_pkg::cmd_t    cmd;
    wrsi_pkg::status_t status;

    // period writes are always taken
    assign cfg_ready = 1'b1;

    wrsi_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wrsi_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .s_price     (s_price),
        .cmd         (cmd),
        .status      (status),
        .m_ready_res (m_ready_res),
        .m_rsi       (m_rsi)
    );

    // checks
    `WRSI_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "beat taken while busy")
    `WRSI_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !m_valid || m_ready, "waiting result lost")
    `WRSI_ASSERT_IMPL(a_rsi_range, m_valid, m_rsi <= wrsi_pkg::RSI_FULL, "rsi above full scale")
    `WRSI_ASSERT_IMPL(a_warmup_zero, m_valid && !m_ready_res, m_rsi == '0, "warm-up rsi not zero")

endmodule

### design/wrsi_datapath.sv
// ----------------------------------------------------------------------------
// wrsi_datapath
// Price state, gain/loss averages, radix-2 divider lanes, ratio unit, output.
// ----------------------------------------------------------------------------
module wrsi_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [wrsi_pkg::PERIOD_W-1:0] cfg_data,
    input  logic [wrsi_pkg::PRICE_W-1:0]  s_price,
    input  wrsi_pkg::cmd_t                cmd,
    output wrsi_pkg::status_t             status,
    output logic                          m_ready_res,
    output logic [wrsi_pkg::RSI_W-1:0]    m_rsi
);

    // saturating accumulator add
    function automatic logic [wrsi_pkg::ACC_W-1:0] sat_add(
        input logic [wrsi_pkg::ACC_W-1:0] a,
        input logic [wrsi_pkg::ACC_W-1:0] b
    );
        logic [wrsi_pkg::ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[wrsi_pkg::ACC_W] ? wrsi_pkg::ACC_MAX : s[wrsi_pkg::ACC_W-1:0];
    endfunction

    logic [wrsi_pkg::PERIOD_W-1:0] period_reg;
    logic [wrsi_pkg::PRICE_W-1:0]  last_price_reg;
    logic [wrsi_pkg::CNT_W-1:0]    count_reg;
    logic [wrsi_pkg::ACC_W-1:0]    avg_gain_reg, avg_gain_next;
    logic [wrsi_pkg::ACC_W-1:0]    avg_loss_reg, avg_loss_next;
    logic [wrsi_pkg::GL_W-1:0]     gain_reg;
    logic [wrsi_pkg::GL_W-1:0]     loss_reg;
    logic [wrsi_pkg::DIVD_W-1:0]   num_g_reg, num_g_next;
    logic [wrsi_pkg::DIVD_W-1:0]   num_l_reg, num_l_next;
    logic [wrsi_pkg::PERIOD_W-1:0] rem_g_reg, rem_g_next;
    logic [wrsi_pkg::PERIOD_W-1:0] rem_l_reg, rem_l_next;
    logic [wrsi_pkg::SUM_W-1:0]    rat_s_reg;
    logic [wrsi_pkg::SUM_W-1:0]    rat_r_reg, rat_r_next;
    logic [wrsi_pkg::RSI_W-1:0]    rat_q_reg, rat_q_next;
    logic                          out_ready_reg;
    logic [wrsi_pkg::RSI_W-1:0]    out_rsi_reg;

    logic [wrsi_pkg::PERIOD_W-1:0] p_eff;
    logic [wrsi_pkg::PERIOD_W-1:0] p_m1;
    logic [wrsi_pkg::ACC_W-1:0]    gain_ext;
    logic [wrsi_pkg::ACC_W-1:0]    loss_ext;
    logic [wrsi_pkg::DIVD_W-1:0]   prod_g;
    logic [wrsi_pkg::DIVD_W-1:0]   prod_l;
    logic [wrsi_pkg::PERIOD_W:0]   trial_g;
    logic [wrsi_pkg::PERIOD_W:0]   trial_l;
    logic                          qbit_g;
    logic                          qbit_l;
    logic [wrsi_pkg::RAT_W-1:0]    rat_part;
    logic [wrsi_pkg::RAT_W-1:0]    rat_s1;
    logic [wrsi_pkg::RAT_W-1:0]    rat_s2;
    logic [wrsi_pkg::RAT_W-1:0]    rat_left;
    logic [1:0]                    rat_n;

    // a zero period behaves as one
    assign p_eff    = (period_reg == '0) ? wrsi_pkg::PERIOD_W'(1) : period_reg;
    assign p_m1     = p_eff - wrsi_pkg::PERIOD_W'(1);
    assign gain_ext = wrsi_pkg::ACC_W'(gain_reg);
    assign loss_ext = wrsi_pkg::ACC_W'(loss_reg);

    // status toward the sequencer
    assign status.cnt_zero  = (count_reg == '0);
    assign status.cnt_lt_p  = (count_reg <  wrsi_pkg::CNT_W'(p_eff));
    assign status.cnt_eq_p  = (count_reg == wrsi_pkg::CNT_W'(p_eff));
    assign status.loss_zero = (avg_loss_reg == '0);

    // period register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= wrsi_pkg::PERIOD_RESET;
        end else if (cfg_valid) begin
            period_reg <= cfg_data;
        end
    end

    // previous price and saturating sample count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_price_reg <= '0;
            count_reg      <= '0;
        end else if (cmd.load) begin
            last_price_reg <= s_price;
            if (count_reg != wrsi_pkg::COUNT_MAX) begin
                count_reg <= count_reg + wrsi_pkg::CNT_W'(1);
            end
        end
    end

    // Q.16 gain and loss of the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (s_price > last_price_reg) begin
                gain_reg <= {s_price - last_price_reg, wrsi_pkg::FRAC_W'(0)};
                loss_reg <= '0;
            end else begin
                gain_reg <= '0;
                loss_reg <= {last_price_reg - s_price, wrsi_pkg::FRAC_W'(0)};
            end
        end
    end

    // warm-up sums or smoothed averages
    always_comb begin
        avg_gain_next = avg_gain_reg;
        avg_loss_next = avg_loss_reg;
        if (cmd.acc) begin
            avg_gain_next = sat_add(avg_gain_reg, gain_ext);
            avg_loss_next = sat_add(avg_loss_reg, loss_ext);
        end else if (cmd.div_done) begin
            avg_gain_next = num_g_reg[wrsi_pkg::ACC_W-1:0];
            avg_loss_next = num_l_reg[wrsi_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_gain_reg <= '0;
            avg_loss_reg <= '0;
        end else begin
            avg_gain_reg <= avg_gain_next;
            avg_loss_reg <= avg_loss_next;
        end
    end

    // smoothing numerators: avg*(p-1) + x
    assign prod_g = wrsi_pkg::DIVD_W'(avg_gain_reg) * wrsi_pkg::DIVD_W'(p_m1);
    assign prod_l = wrsi_pkg::DIVD_W'(avg_loss_reg) * wrsi_pkg::DIVD_W'(p_m1);

    // restoring divide by p, one quotient bit per cycle and lane
    assign trial_g = {rem_g_reg, num_g_reg[wrsi_pkg::DIVD_W-1]};
    assign trial_l = {rem_l_reg, num_l_reg[wrsi_pkg::DIVD_W-1]};
    assign qbit_g  = (trial_g >= {1'b0, p_eff});
    assign qbit_l  = (trial_l >= {1'b0, p_eff});

    always_comb begin
        num_g_next = num_g_reg;
        num_l_next = num_l_reg;
        rem_g_next = rem_g_reg;
        rem_l_next = rem_l_reg;
        if (cmd.seed) begin
            num_g_next = wrsi_pkg::DIVD_W'(sat_add(avg_gain_reg, gain_ext));
            num_l_next = wrsi_pkg::DIVD_W'(sat_add(avg_loss_reg, loss_ext));
            rem_g_next = '0;
            rem_l_next = '0;
        end else if (cmd.smooth) begin
            num_g_next = prod_g + wrsi_pkg::DIVD_W'(gain_reg);
            num_l_next = prod_l + wrsi_pkg::DIVD_W'(loss_reg);
            rem_g_next = '0;
            rem_l_next = '0;
        end else if (cmd.div_step) begin
            num_g_next = {num_g_reg[wrsi_pkg::DIVD_W-2:0], qbit_g};
            num_l_next = {num_l_reg[wrsi_pkg::DIVD_W-2:0], qbit_l};
            rem_g_next = qbit_g ? wrsi_pkg::PERIOD_W'(trial_g - {1'b0, p_eff})
                                : trial_g[wrsi_pkg::PERIOD_W-1:0];
            rem_l_next = qbit_l ? wrsi_pkg::PERIOD_W'(trial_l - {1'b0, p_eff})
                                : trial_l[wrsi_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        num_g_reg <= num_g_next;
        num_l_reg <= num_l_next;
        rem_g_reg <= rem_g_next;
        rem_l_reg <= rem_l_next;
    end

    // ratio step: r' = 2r + bit*G, then take out 0, 1 or 2 times S
    assign rat_part = wrsi_pkg::RAT_W'({rat_r_reg, 1'b0})
                    + (wrsi_pkg::RSI_FULL[cmd.ratio_idx] ? wrsi_pkg::RAT_W'(avg_gain_reg)
                                                         : '0);
    assign rat_s1   = wrsi_pkg::RAT_W'(rat_s_reg);
    assign rat_s2   = wrsi_pkg::RAT_W'({rat_s_reg, 1'b0});

    always_comb begin
        if (rat_part >= rat_s2) begin
            rat_left = rat_part - rat_s2;
            rat_n    = 2'd2;
        end else if (rat_part >= rat_s1) begin
            rat_left = rat_part - rat_s1;
            rat_n    = 2'd1;
        end else begin
            rat_left = rat_part;
            rat_n    = 2'd0;
        end
    end

    always_comb begin
        rat_r_next = rat_r_reg;
        rat_q_next = rat_q_reg;
        if (cmd.ratio_init) begin
            rat_r_next = '0;
            rat_q_next = '0;
        end else if (cmd.ratio_step) begin
            rat_r_next = rat_left[wrsi_pkg::SUM_W-1:0];
            rat_q_next = {rat_q_reg[wrsi_pkg::RSI_W-2:0], 1'b0}
                       + wrsi_pkg::RSI_W'(rat_n);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ratio_init) begin
            rat_s_reg <= {1'b0, avg_gain_reg} + {1'b0, avg_loss_reg};
        end
        rat_r_reg <= rat_r_next;
        rat_q_reg <= rat_q_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_ready_reg <= cmd.res_ready;
            if (!cmd.res_ready) begin
                out_rsi_reg <= '0;
            end else if (status.loss_zero) begin
                out_rsi_reg <= wrsi_pkg::RSI_FULL;
            end else begin
                out_rsi_reg <= rat_q_reg;
            end
        end
    end

    assign m_ready_res = out_ready_reg;
    assign m_rsi       = out_rsi_reg;

endmodule

### design/wrsi_controller.sv
// ----------------------------------------------------------------------------
// wrsi_controller
// Sequencer: beat intake, warm-up/seed/smooth path, divider and ratio loops.
// ----------------------------------------------------------------------------
module wrsi_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  wrsi_pkg::status_t status,
    output wrsi_pkg::cmd_t    cmd
);

    wrsi_pkg::state_t              state_reg, state_next;
    logic [wrsi_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          rdy_reg, rdy_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          accept;
    logic                          div_last;
    logic                          ratio_last;
    logic                          slot_free;

    assign accept     = s_valid && (state_reg == wrsi_pkg::ST_IDLE);
    assign div_last   = (step_reg == wrsi_pkg::STEP_W'(wrsi_pkg::DIV_STEPS - 1));
    assign ratio_last = (step_reg == wrsi_pkg::STEP_W'(wrsi_pkg::RATIO_STEPS - 1));
    assign slot_free  = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wrsi_pkg::ST_IDLE: begin
                if (accept) begin
                    if (status.cnt_zero) begin
                        state_next = wrsi_pkg::ST_DONE;
                    end else if (status.cnt_lt_p) begin
                        state_next = wrsi_pkg::ST_ACC;
                    end else if (status.cnt_eq_p) begin
                        state_next = wrsi_pkg::ST_SEED;
                    end else begin
                        state_next = wrsi_pkg::ST_SMOOTH;
                    end
                end
            end
            wrsi_pkg::ST_ACC:        state_next = wrsi_pkg::ST_DONE;
            wrsi_pkg::ST_SEED:       state_next = wrsi_pkg::ST_DIV;
            wrsi_pkg::ST_SMOOTH:     state_next = wrsi_pkg::ST_DIV;
            wrsi_pkg::ST_DIV: begin
                if (div_last) begin
                    state_next = wrsi_pkg::ST_DIV_END;
                end
            end
            wrsi_pkg::ST_DIV_END:    state_next = wrsi_pkg::ST_RATIO_INIT;
            wrsi_pkg::ST_RATIO_INIT: begin
                state_next = status.loss_zero ? wrsi_pkg::ST_DONE : wrsi_pkg::ST_RATIO;
            end
            wrsi_pkg::ST_RATIO: begin
                if (ratio_last) begin
                    state_next = wrsi_pkg::ST_DONE;
                end
            end
            wrsi_pkg::ST_DONE: begin
                if (slot_free) begin
                    state_next = wrsi_pkg::ST_IDLE;
                end
            end
            default:                 state_next = wrsi_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd           = '0;
        s_ready       = 1'b0;
        cmd.res_ready = rdy_reg;
        cmd.ratio_idx = wrsi_pkg::RSI_IDX_W'(wrsi_pkg::RATIO_STEPS - 1)
                      - step_reg[wrsi_pkg::RSI_IDX_W-1:0];
        case (state_reg)
            wrsi_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            wrsi_pkg::ST_ACC:        cmd.acc        = 1'b1;
            wrsi_pkg::ST_SEED:       cmd.seed       = 1'b1;
            wrsi_pkg::ST_SMOOTH:     cmd.smooth     = 1'b1;
            wrsi_pkg::ST_DIV:        cmd.div_step   = 1'b1;
            wrsi_pkg::ST_DIV_END:    cmd.div_done   = 1'b1;
            wrsi_pkg::ST_RATIO_INIT: cmd.ratio_init = 1'b1;
            wrsi_pkg::ST_RATIO:      cmd.ratio_step = 1'b1;
            wrsi_pkg::ST_DONE:       cmd.out_load   = slot_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

    // loop counter, ready flag, output valid
    always_comb begin
        step_next = '0;
        if ((state_reg == wrsi_pkg::ST_DIV && !div_last) ||
            (state_reg == wrsi_pkg::ST_RATIO && !ratio_last)) begin
            step_next = step_reg + wrsi_pkg::STEP_W'(1);
        end
        rdy_next = rdy_reg;
        if (accept) begin
            rdy_next = !status.cnt_zero && !status.cnt_lt_p;
        end
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wrsi_pkg::ST_IDLE;
            step_reg    <= '0;
            rdy_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            rdy_reg     <= rdy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming Wilder RSI unit. A queue-fed driver
// sends prices, a monitor compares every result beat with a local model of
// the warm-up sums, the seeding divide, the smoothing and the RSI ratio.
// The period register is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned                  STALL_LIMIT = 5000;
    localparam int unsigned                  DRAIN_WAIT  = 100;
    localparam logic [wrsi_pkg::PRICE_W-1:0] PRICE_TOP   = '1;

    typedef struct packed {
        logic                       ready_res;
        logic [wrsi_pkg::RSI_W-1:0] rsi;
    } rsi_beat_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // unit ports
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic [wrsi_pkg::PRICE_W-1:0]  s_price   = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic                          m_ready_res;
    logic [wrsi_pkg::RSI_W-1:0]    m_rsi;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [wrsi_pkg::PERIOD_W-1:0] cfg_data  = '0;

    wilder_rsi_stream_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_price     (s_price),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ready_res (m_ready_res),
        .m_rsi       (m_rsi),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // model state: period register, last price, count, gain/loss accumulators
    logic [wrsi_pkg::PERIOD_W-1:0] period_q   = wrsi_pkg::PERIOD_RESET;
    logic [wrsi_pkg::PRICE_W-1:0]  last_px_q  = '0;
    logic [wrsi_pkg::CNT_W-1:0]    seen_q     = '0;
    logic [wrsi_pkg::ACC_W-1:0]    gain_avg_q = '0;
    logic [wrsi_pkg::ACC_W-1:0]    loss_avg_q = '0;

    rsi_beat_t                    rsi_expected[$];
    logic [wrsi_pkg::PRICE_W-1:0] price_queue[$];
    logic [wrsi_pkg::PRICE_W-1:0] last_sent    = '0;
    int unsigned                  items_queued = 0;
    int unsigned                  items_taken  = 0;
    int unsigned                  err_count    = 0;
    int unsigned                  idle_cycles  = 0;
    bit                           calm_tail    = 1'b0;

    // warm-up sums clip at the accumulator ceiling
    function automatic logic [wrsi_pkg::ACC_W-1:0] acc_add(
        input logic [wrsi_pkg::ACC_W-1:0] acc,
        input logic [63:0]                inc
    );
        logic [63:0] total;
        total = 64'(acc) + inc;
        return (total > 64'(wrsi_pkg::ACC_MAX)) ? wrsi_pkg::ACC_MAX
                                                 : total[wrsi_pkg::ACC_W-1:0];
    endfunction

    // advance the RSI state by one price and return the beat it produces
    function automatic rsi_beat_t predict_rsi(input logic [wrsi_pkg::PRICE_W-1:0] px);
        logic [63:0]  div_p;
        logic [63:0]  rise;
        logic [63:0]  fall;
        logic [127:0] scaled;
        rsi_beat_t    beat;
        beat  = '0;
        rise  = '0;
        fall  = '0;
        // a zero period behaves as one
        div_p = (period_q == '0) ? 64'd1 : 64'(period_q);
        if (seen_q != '0) begin
            if (px > last_px_q) begin
                rise = 64'(px - last_px_q) << wrsi_pkg::FRAC_W;
            end else begin
                fall = 64'(last_px_q - px) << wrsi_pkg::FRAC_W;
            end
            if (64'(seen_q) < div_p) begin
                gain_avg_q = acc_add(gain_avg_q, rise);
                loss_avg_q = acc_add(loss_avg_q, fall);
            end else if (64'(seen_q) == div_p) begin
                // seed: plain mean of the summed changes
                gain_avg_q     = wrsi_pkg::ACC_W'(64'(acc_add(gain_avg_q, rise)) / div_p);
                loss_avg_q     = wrsi_pkg::ACC_W'(64'(acc_add(loss_avg_q, fall)) / div_p);
                beat.ready_res = 1'b1;
            end else begin
                // Wilder smoothing, 64-bit product wraps as in the datapath
                gain_avg_q     = wrsi_pkg::ACC_W'(
                                 (64'(gain_avg_q) * (div_p - 64'd1) + rise) / div_p);
                loss_avg_q     = wrsi_pkg::ACC_W'(
                                 (64'(loss_avg_q) * (div_p - 64'd1) + fall) / div_p);
                beat.ready_res = 1'b1;
            end
        end
        last_px_q = px;
        if (seen_q != wrsi_pkg::COUNT_MAX) begin
            seen_q++;
        end
        if (beat.ready_res) begin
            if (loss_avg_q == '0) begin
                beat.rsi = wrsi_pkg::RSI_FULL;
            end else begin
                scaled   = 128'(gain_avg_q) * 128'(wrsi_pkg::RSI_FULL);
                beat.rsi = wrsi_pkg::RSI_W'(scaled /
                                            (128'(gain_avg_q) + 128'(loss_avg_q)));
            end
        end
        return beat;
    endfunction

    // mostly a random walk, with jumps, repeats and rail values mixed in
    function automatic logic [wrsi_pkg::PRICE_W-1:0] next_price(
        input logic [wrsi_pkg::PRICE_W-1:0] prev
    );
        logic [wrsi_pkg::PRICE_W:0] walk;
        int unsigned                step;
        step = $urandom_range(0, 4000);
        case ($urandom_range(0, 9))
            0: begin
                return wrsi_pkg::PRICE_W'($urandom);
            end
            1: begin
                return prev;
            end
            2: begin
                return ($urandom_range(0, 1) == 1) ? PRICE_TOP : '0;
            end
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    walk = {1'b0, prev} + (wrsi_pkg::PRICE_W + 1)'(step);
                    return walk[wrsi_pkg::PRICE_W] ? PRICE_TOP
                                                   : walk[wrsi_pkg::PRICE_W-1:0];
                end
                return (prev > step) ? prev - step : '0;
            end
        endcase
    endfunction

    // price driver: one beat in flight, random idle bursts between beats
    always @(posedge aclk) begin : drive_prices
        logic        nxt_valid;
        int unsigned src_gap;
        if (!aresetn) begin
            src_gap = 0;
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            if (s_valid && s_ready) begin
                rsi_expected = {rsi_expected, predict_rsi(s_price)};
                items_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 8);
                end else if (price_queue.size() != 0) begin
                    s_price <= price_queue.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // result monitor and back-pressure
    always @(posedge aclk) begin : check_results
        rsi_beat_t   want;
        logic        nxt_ready;
        int unsigned sink_gap;
        if (!aresetn) begin
            sink_gap = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rsi_expected.size() == 0) begin
                    $error("unexpected result beat: ready_res=%0d rsi=%0d",
                           m_ready_res, m_rsi);
                    err_count++;
                end else begin
                    want = rsi_expected.pop_front();
                    if (m_ready_res !== want.ready_res) begin
                        $error("ready_res: expected %0d, actual %0d",
                               want.ready_res, m_ready_res);
                        err_count++;
                    end
                    if (m_rsi !== want.rsi) begin
                        $error("rsi: expected %0d, actual %0d", want.rsi, m_rsi);
                        err_count++;
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                nxt_ready = 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                sink_gap  = $urandom_range(0, 8);
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_ready <= nxt_ready;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // block until every queued price is taken and every result checked
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (items_taken != items_queued || rsi_expected.size() != 0);
    endtask

    task automatic write_period(input logic [wrsi_pkg::PERIOD_W-1:0] value);
        wait_drained();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        period_q = value;
    endtask

    task automatic queue_price(input logic [wrsi_pkg::PRICE_W-1:0] px);
        price_queue = {price_queue, px};
        items_queued++;
        last_sent = px;
    endtask

    // stimulus
    initial begin
        int unsigned                   n_items;
        logic [wrsi_pkg::PERIOD_W-1:0] per;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first price under the reset period: nothing to compare yet
        queue_price('0);
        // period 1: full-scale rise, full-scale fall, flat, small rise
        write_period(8'd1);
        queue_price(PRICE_TOP);
        queue_price('0);
        queue_price('0);
        queue_price(32'd7);
        // zero period acts as one
        write_period('0);
        queue_price(32'd7);
        queue_price(32'd3);
        queue_price(32'd9);
        // period raised past the count: warm-up resumes on held averages
        write_period(8'd12);
        queue_price(32'd100);
        queue_price(32'd200);
        queue_price(32'd150);
        queue_price(32'd150);
        queue_price(32'd300);
        // period dropped below the count: straight to smoothing
        write_period(8'd4);
        queue_price(32'd1000);
        queue_price(32'd1000);
        queue_price(32'h5555_5555);
        queue_price(32'hAAAA_AAAA);

        // longest period, run until it seeds and smooths a while
        write_period(8'd255);
        n_items = 255 - items_queued + $urandom_range(15, 30);
        repeat (n_items) queue_price(next_price(last_sent));

        // random phases; count saturates along the way
        while (items_queued < 560) begin
            case ($urandom_range(0, 5))
                0:       per = 8'd1;
                1:       per = 8'd255;
                2:       per = wrsi_pkg::PERIOD_RESET;
                3:       per = '0;
                default: per = wrsi_pkg::PERIOD_W'($urandom_range(2, 254));
            endcase
            write_period(per);
            n_items = $urandom_range(25, 50);
            repeat (n_items) queue_price(next_price(last_sent));
        end

        // tail at full rate on both sides
        write_period(wrsi_pkg::PERIOD_W'($urandom_range(1, 40)));
        calm_tail = 1'b1;
        repeat (40) queue_price(next_price(last_sent));

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
